/* rtl/rbba_pkg.sv */
// ----------------------------------------------------------------------------
// rbba_pkg
// Shared widths, defaults and codes for the ring buffer block allocator.
// ----------------------------------------------------------------------------
package rbba_pkg;

  localparam int SIZE_W = 21;

  localparam int DEFAULT_MAX_BLOCKS = 32;
  localparam int DEFAULT_ADDR_BITS  = 20;
  localparam int DEFAULT_TAG_BITS   = 32;

  typedef enum logic [1:0] {
    KIND_EVICT  = 2'd0,
    KIND_GRANT  = 2'd1,
    KIND_REJECT = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_CHECK
  } st_t;

endpackage

/* rtl/ring_buffer_block_allocator_core.sv */
// ----------------------------------------------------------------------------
// ring_buffer_block_allocator_core
// Circular byte region allocator keeping live blocks as a FIFO of records;
// oldest blocks are evicted until the free gap holds the request and a record slot is free.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. An oversized request
// gives one reject result in the next cycle. Otherwise each gap check needs
// a registered read of the oldest record from the record memory read port
// followed by one shared subtract-and-compare, and each evicted block is
// followed by a fresh read of the new head. Results appear on the result
// ports for exactly one cycle marked by result_valid and cannot be held off;
// last_of_run marks the final result of a request. capacity is written only
// while no block is live.
module ring_buffer_block_allocator_core #(
  parameter int MAX_BLOCKS = rbba_pkg::DEFAULT_MAX_BLOCKS,
  parameter int ADDR_BITS  = rbba_pkg::DEFAULT_ADDR_BITS,
  parameter int TAG_BITS   = rbba_pkg::DEFAULT_TAG_BITS
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  logic [rbba_pkg::SIZE_W-1:0] req_size,
  input  logic [TAG_BITS-1:0]        req_tag,
  input  logic                       capacity_we,
  input  logic [rbba_pkg::SIZE_W-1:0] capacity_wdata,
  output logic                       result_valid,
  output logic [1:0]                 kind,
  output logic [TAG_BITS-1:0]        tag,
  output logic [ADDR_BITS-1:0]       offset,
  output logic                       last_of_run
);

  localparam int SW    = rbba_pkg::SIZE_W;
  localparam int IDX_W = $clog2(MAX_BLOCKS);
  localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
  localparam logic [63:0] ADDR_LIMIT = 64'(1) << ADDR_BITS;

  rbba_pkg::st_t state, state_next;

  logic [IDX_W-1:0] head, head_next;
  logic [CNT_W-1:0] count, count_next;
  logic [SW-1:0]    capacity;
  logic [SW-1:0]    size_q;
  logic [TAG_BITS-1:0] tag_q;
  logic [SW-1:0]    tail_end, tail_end_next;
  logic             capture;

  logic [TAG_BITS-1:0] mem_tag [MAX_BLOCKS];
  logic [SW-1:0]       mem_begin [MAX_BLOCKS];
  logic [TAG_BITS-1:0] rd_tag;
  logic [SW-1:0]       rd_begin;
  logic                mem_we;
  logic [IDX_W-1:0]    slot;
  logic [IDX_W:0]      slot_sum;

  logic [SW-1:0] gap_begin, gap_end;
  logic          fit;
  logic [SW-1:0] cap_sat;

  logic                res_valid_next;
  rbba_pkg::kind_t     res_kind_next;
  logic [TAG_BITS-1:0] res_tag_next;
  logic [ADDR_BITS-1:0] res_off_next;
  logic                res_last_next;

  assign busy = rst || (state != rbba_pkg::ST_IDLE);

  assign cap_sat = (64'(capacity_wdata) > ADDR_LIMIT) ? SW'(ADDR_LIMIT) : capacity_wdata;

  assign slot_sum = (IDX_W + 1)'(head) + (IDX_W + 1)'(count);
  assign slot = (slot_sum >= (IDX_W + 1)'(MAX_BLOCKS)) ?
                IDX_W'(slot_sum - (IDX_W + 1)'(MAX_BLOCKS)) : IDX_W'(slot_sum);

  always_comb begin
    if (count == '0) begin
      gap_begin = '0;
      gap_end   = capacity;
    end else if (rd_begin > tail_end) begin
      gap_begin = tail_end;
      gap_end   = rd_begin;
    end else if (rd_begin != '0) begin
      gap_begin = '0;
      gap_end   = rd_begin;
    end else begin
      gap_begin = tail_end;
      gap_end   = capacity;
    end
    fit = (gap_end - gap_begin) >= size_q;
  end

  always_comb begin
    state_next     = state;
    head_next      = head;
    count_next     = count;
    tail_end_next  = tail_end;
    capture        = 1'b0;
    mem_we         = 1'b0;
    res_valid_next = 1'b0;
    res_kind_next  = rbba_pkg::KIND_EVICT;
    res_tag_next   = rd_tag;
    res_off_next   = '0;
    res_last_next  = 1'b0;
    case (state)
      rbba_pkg::ST_IDLE: begin
        if (start) begin
          capture = 1'b1;
          if (req_size > capacity) begin
            res_valid_next = 1'b1;
            res_kind_next  = rbba_pkg::KIND_REJECT;
            res_tag_next   = req_tag;
            res_last_next  = 1'b1;
          end else begin
            state_next = rbba_pkg::ST_READ;
          end
        end
      end
      rbba_pkg::ST_READ: begin
        state_next = rbba_pkg::ST_CHECK;
      end
      rbba_pkg::ST_CHECK: begin
        if ((count == CNT_W'(MAX_BLOCKS)) || !fit) begin
          // drop the oldest block and re-read the new head
          res_valid_next = 1'b1;
          res_kind_next  = rbba_pkg::KIND_EVICT;
          res_tag_next   = rd_tag;
          head_next      = (head == IDX_W'(MAX_BLOCKS - 1)) ? '0 : head + IDX_W'(1);
          count_next     = count - CNT_W'(1);
          state_next     = rbba_pkg::ST_READ;
        end else begin
          mem_we         = 1'b1;
          tail_end_next  = gap_begin + size_q;
          count_next     = count + CNT_W'(1);
          res_valid_next = 1'b1;
          res_kind_next  = rbba_pkg::KIND_GRANT;
          res_tag_next   = tag_q;
          res_off_next   = ADDR_BITS'(gap_begin);
          res_last_next  = 1'b1;
          state_next     = rbba_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = rbba_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= rbba_pkg::ST_IDLE;
      head         <= '0;
      count        <= '0;
      capacity     <= '0;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      head         <= head_next;
      count        <= count_next;
      result_valid <= res_valid_next;
      if (capacity_we && (count == '0)) begin
        capacity <= cap_sat;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (capture) begin
      size_q <= req_size;
      tag_q  <= req_tag;
    end
    tail_end    <= tail_end_next;
    kind        <= res_kind_next;
    tag         <= res_tag_next;
    offset      <= res_off_next;
    last_of_run <= res_last_next;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem_tag[slot]   <= tag_q;
      mem_begin[slot] <= gap_begin;
    end
    rd_tag   <= mem_tag[head];
    rd_begin <= mem_begin[head];
  end

  a_last_ends_run: assert property (@(posedge clk) disable iff (rst)
    result_valid && last_of_run |-> !busy)
    else $error("final result while request still running");

  a_evict_continues: assert property (@(posedge clk) disable iff (rst)
    result_valid && (kind == rbba_pkg::KIND_EVICT) |-> busy && !last_of_run)
    else $error("eviction did not continue the request");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(MAX_BLOCKS))
    else $error("block count above ring depth");

  a_accept_progress: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy || (result_valid && (kind == rbba_pkg::KIND_REJECT)))
    else $error("accepted request neither started nor rejected");

endmodule
